/* design/csdc_pkg.sv */
// Shared constants, row formats and controller/datapath command types for the
// column statistics and distinct-value counter. No dependencies.
`timescale 1ns / 1ps

package csdc_pkg;

  localparam int NUM_COLUMNS  = 49;
  localparam int SET_CAPACITY = 16384;

  localparam int COL_W   = 6;
  localparam int VALUE_W = 32;
  localparam int CNT_W   = 40;
  localparam int DIST_W  = 15;

  localparam int SLOT_W       = $clog2(SET_CAPACITY);
  localparam int SET_DEPTH    = NUM_COLUMNS * SET_CAPACITY;
  localparam int KEY_ADDR_W   = $clog2(SET_DEPTH);
  localparam int STATS_ADDR_W = $clog2(NUM_COLUMNS);

  localparam logic [VALUE_W-1:0] HASH_MULT = 32'd2654435761;
  localparam logic [CNT_W-1:0]   CNT_MAX   = {CNT_W{1'b1}};
  localparam logic [DIST_W-1:0]  DIST_MAX  = {DIST_W{1'b1}};

  // One row of per-column statistics.
  typedef struct packed {
    logic signed [VALUE_W-1:0] min_v;
    logic signed [VALUE_W-1:0] max_v;
    logic [CNT_W-1:0]          zeros;
    logic [DIST_W-1:0]         distinct;
  } stats_row_t;

  localparam stats_row_t STATS_RESET = '{
    min_v:    32'sh7FFF_FFFF,
    max_v:    32'sh8000_0000,
    zeros:    '0,
    distinct: '0
  };

  // One hash-set slot: occupancy flag and stored key.
  typedef struct packed {
    logic               used;
    logic [VALUE_W-1:0] key;
  } slot_word_t;

  typedef struct packed {
    logic clear_step;
    logic load;
    logic hash;
    logic probe_next;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic col_valid;
    logic slot_used;
    logic key_match;
    logic probe_last;
    logic out_free;
  } dp_status_t;

endpackage

/* design/csdc_in_if.sv */
// Request channel carrying one column-tagged value into the profiler.
// Depends on csdc_pkg.
`timescale 1ns / 1ps

interface csdc_in_if import csdc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [COL_W-1:0]          column;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output column, output value, input ready);
  modport sink   (input valid, input column, input value, output ready);
endinterface

/* design/csdc_out_if.sv */
// Result channel carrying the passed value and its column statistics.
// Depends on csdc_pkg.
`timescale 1ns / 1ps

interface csdc_out_if import csdc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value_out;
  logic [COL_W-1:0]          column_out;
  logic signed [VALUE_W-1:0] col_min;
  logic signed [VALUE_W-1:0] col_max;
  logic [CNT_W-1:0]          zero_count;
  logic [DIST_W-1:0]         distinct_count;
  logic [CNT_W-1:0]          row_count;
  logic                      set_full;

  modport source (output valid, output value_out, output column_out, output col_min,
                  output col_max, output zero_count, output distinct_count,
                  output row_count, output set_full, input ready);
  modport sink   (input valid, input value_out, input column_out, input col_min,
                  input col_max, input zero_count, input distinct_count,
                  input row_count, input set_full, output ready);
endinterface

/* design/column_stats_distinct_counter.sv */
// Top level of the streaming column profiler with per-column distinct counting.
// Depends on csdc_pkg, csdc_in_if, csdc_out_if, csdc_ctrl and csdc_dp.
`timescale 1ns / 1ps

// Each request carries a signed 32-bit value and its column index. The block
// keeps, for every column, the running minimum and maximum, a saturating count
// of zeros and a count of distinct values, and returns one result per request
// with the value passed through and that column's updated figures. A record
// counter advances on every value of the last column. Distinct values live in
// a per-column open-addressing hash set (multiplicative hash, linear probing)
// held in one large slot RAM. After reset the block sweeps that RAM once to
// mark all slots empty; no request is accepted until the sweep ends. After
// that, a request is loaded and hashed, and the probe then visits slots, with
// one read of the slot RAM and one compare per slot, until it finds an empty
// or matching slot. A column whose set holds no free slot stops after
// SET_CAPACITY probes and flags set_full. The result sits in an output
// register, so a finished result waiting for its consumer does not stop the
// next request from being accepted and probed; that request finishes once
// the output register is free. A column index beyond the last column changes
// no state and returns zero statistics with the current record count.
module column_stats_distinct_counter import csdc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  csdc_in_if.sink     in_chan,
  csdc_out_if.source  out_chan
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // The controller sequences the clearing pass and the probe loop.
  csdc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .cmd      (cmd),
    .status   (status)
  );

  // The datapath holds the RAMs, the update logic and the result register.
  csdc_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .status       (status),
    .in_column    (in_chan.column),
    .in_value     (in_chan.value),
    .out_valid    (out_chan.valid),
    .out_ready    (out_chan.ready),
    .out_value    (out_chan.value_out),
    .out_column   (out_chan.column_out),
    .out_min      (out_chan.col_min),
    .out_max      (out_chan.col_max),
    .out_zeros    (out_chan.zero_count),
    .out_distinct (out_chan.distinct_count),
    .out_rows     (out_chan.row_count),
    .out_full     (out_chan.set_full)
  );

endmodule

/* design/csdc_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module csdc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/csdc_ctrl.sv */
// Sequencing state machine: clearing pass, item accept, hash, probe loop, finish.
// Depends on csdc_pkg; drives csdc_dp through dp_cmd_t and reads dp_status_t.
`timescale 1ns / 1ps

module csdc_ctrl import csdc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output dp_cmd_t    cmd,
  input  dp_status_t status
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_READ,
    S_CHECK
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   probe_done;

  // A probe ends on an out-of-range column, an empty slot, a match or the last slot.
  assign probe_done = !status.col_valid || !status.slot_used || status.key_match ||
                      status.probe_last;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_HASH;
        end
      end
      S_HASH: begin
        cmd.hash  = 1'b1;
        state_nxt = S_READ;
      end
      S_READ: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (probe_done) begin
          if (status.out_free) begin
            cmd.finish = 1'b1;
            state_nxt  = S_IDLE;
          end
        end else begin
          cmd.probe_next = 1'b1;
          state_nxt      = S_READ;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* design/csdc_dp.sv */
// Datapath: item registers, hash, slot and stats RAMs, update logic, output register.
// Depends on csdc_pkg and csdc_ram; commanded by csdc_ctrl.
`timescale 1ns / 1ps

module csdc_dp import csdc_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  dp_cmd_t                   cmd,
  output dp_status_t                status,
  input  logic [COL_W-1:0]          in_column,
  input  logic signed [VALUE_W-1:0] in_value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [VALUE_W-1:0] out_value,
  output logic [COL_W-1:0]          out_column,
  output logic signed [VALUE_W-1:0] out_min,
  output logic signed [VALUE_W-1:0] out_max,
  output logic [CNT_W-1:0]          out_zeros,
  output logic [DIST_W-1:0]         out_distinct,
  output logic [CNT_W-1:0]          out_rows,
  output logic                      out_full
);

  logic [COL_W-1:0]          col_r;
  logic signed [VALUE_W-1:0] value_r;
  logic [SLOT_W-1:0]         slot_r;
  logic [SLOT_W-1:0]         probe_r;
  logic [KEY_ADDR_W-1:0]     clr_cnt_r;
  logic [CNT_W-1:0]          rows_r;
  logic [CNT_W-1:0]          rows_nxt;
  logic                      out_valid_r;

  logic signed [VALUE_W-1:0] o_value_r;
  logic [COL_W-1:0]          o_column_r;
  logic signed [VALUE_W-1:0] o_min_r;
  logic signed [VALUE_W-1:0] o_max_r;
  logic [CNT_W-1:0]          o_zeros_r;
  logic [DIST_W-1:0]         o_distinct_r;
  logic [CNT_W-1:0]          o_rows_r;
  logic                      o_full_r;

  logic [VALUE_W-1:0]      hash_w;
  logic                    col_valid;
  logic                    set_full;
  logic                    insert;

  slot_word_t              slot_rd;
  slot_word_t              slot_wdata;
  logic                    slot_we;
  logic [KEY_ADDR_W-1:0]   slot_waddr;
  logic [KEY_ADDR_W-1:0]   slot_raddr;

  stats_row_t              stats_rd;
  stats_row_t              stats_upd;
  stats_row_t              stats_wdata;
  logic                    stats_we;
  logic [STATS_ADDR_W-1:0] stats_waddr;

  assign hash_w    = value_r * HASH_MULT;
  assign col_valid = col_r < COL_W'(NUM_COLUMNS);

  assign status.clear_last = clr_cnt_r == KEY_ADDR_W'(SET_DEPTH - 1);
  assign status.col_valid  = col_valid;
  assign status.slot_used  = slot_rd.used;
  assign status.key_match  = slot_rd.key == value_r;
  assign status.probe_last = probe_r == '1;
  assign status.out_free   = !out_valid_r || out_ready;

  assign set_full = slot_rd.used && (slot_rd.key != value_r) && (probe_r == '1);
  assign insert   = col_valid && !slot_rd.used;

  // Slot RAM: the clearing pass writes empty words, an insert writes the key.
  assign slot_raddr = KEY_ADDR_W'({col_r, slot_r});
  always_comb begin
    slot_we    = 1'b0;
    slot_waddr = slot_raddr;
    slot_wdata = '{used: 1'b1, key: value_r};
    if (cmd.clear_step) begin
      slot_we    = 1'b1;
      slot_waddr = clr_cnt_r;
      slot_wdata = '0;
    end else if (cmd.finish && insert) begin
      slot_we = 1'b1;
    end
  end

  csdc_ram #(
    .WIDTH ($bits(slot_word_t)),
    .DEPTH (SET_DEPTH)
  ) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (slot_raddr),
    .rdata (slot_rd)
  );

  // Updated statistics row for the current column.
  always_comb begin
    stats_upd       = stats_rd;
    if (value_r < stats_rd.min_v) begin
      stats_upd.min_v = value_r;
    end
    if (value_r > stats_rd.max_v) begin
      stats_upd.max_v = value_r;
    end
    if (value_r == '0 && stats_rd.zeros != CNT_MAX) begin
      stats_upd.zeros = stats_rd.zeros + CNT_W'(1);
    end
    if (insert && stats_rd.distinct != DIST_MAX) begin
      stats_upd.distinct = stats_rd.distinct + DIST_W'(1);
    end
  end

  always_comb begin
    stats_we    = 1'b0;
    stats_waddr = col_r[STATS_ADDR_W-1:0];
    stats_wdata = stats_upd;
    if (cmd.clear_step) begin
      stats_we    = clr_cnt_r < KEY_ADDR_W'(NUM_COLUMNS);
      stats_waddr = clr_cnt_r[STATS_ADDR_W-1:0];
      stats_wdata = STATS_RESET;
    end else if (cmd.finish && col_valid) begin
      stats_we = 1'b1;
    end
  end

  csdc_ram #(
    .WIDTH ($bits(stats_row_t)),
    .DEPTH (NUM_COLUMNS)
  ) u_stats_ram (
    .clk   (clk),
    .we    (stats_we),
    .waddr (stats_waddr),
    .wdata (stats_wdata),
    .raddr (col_r[STATS_ADDR_W-1:0]),
    .rdata (stats_rd)
  );

  always_comb begin
    rows_nxt = rows_r;
    if (col_valid && col_r == COL_W'(NUM_COLUMNS - 1) && rows_r != CNT_MAX) begin
      rows_nxt = rows_r + CNT_W'(1);
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      rows_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clear_step) begin
        clr_cnt_r <= clr_cnt_r + KEY_ADDR_W'(1);
      end
      if (cmd.finish) begin
        rows_r      <= rows_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Item and output payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      col_r   <= in_column;
      value_r <= in_value;
    end
    if (cmd.hash) begin
      slot_r  <= hash_w[SLOT_W-1:0];
      probe_r <= '0;
    end else if (cmd.probe_next) begin
      slot_r  <= slot_r + SLOT_W'(1);
      probe_r <= probe_r + SLOT_W'(1);
    end
    if (cmd.finish) begin
      o_value_r  <= value_r;
      o_column_r <= col_r;
      o_rows_r   <= rows_nxt;
      if (col_valid) begin
        o_min_r      <= stats_upd.min_v;
        o_max_r      <= stats_upd.max_v;
        o_zeros_r    <= stats_upd.zeros;
        o_distinct_r <= stats_upd.distinct;
        o_full_r     <= set_full;
      end else begin
        o_min_r      <= '0;
        o_max_r      <= '0;
        o_zeros_r    <= '0;
        o_distinct_r <= '0;
        o_full_r     <= 1'b0;
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_value    = o_value_r;
  assign out_column   = o_column_r;
  assign out_min      = o_min_r;
  assign out_max      = o_max_r;
  assign out_zeros    = o_zeros_r;
  assign out_distinct = o_distinct_r;
  assign out_rows     = o_rows_r;
  assign out_full     = o_full_r;

endmodule
